>>> design/dq_pkg.sv
`default_nettype none

package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [WORD_W-1:0] word_t;

    // request to the entry RAM
    typedef struct packed {
        logic  we;
        logic  re;
        idx_t  addr;
        word_t wdata;
    } mem_cmd_t;

    // result waiting for the RAM read data
    typedef struct packed {
        logic    valid;
        logic    pop_ok;
        status_t status;
        cnt_t    count;
    } rsp_meta_t;

    // pointer state, for observation
    typedef struct packed {
        cnt_t count;
        idx_t head;
        idx_t tail;
        logic empty;
        logic full;
    } dq_stat_t;

    function automatic idx_t ring_next(input idx_t i);
        return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
    endfunction

    function automatic idx_t ring_prev(input idx_t i);
        return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
    endfunction

endpackage

`default_nettype wire

>>> design/dq_if.sv
`default_nettype none

interface dq_req_if;
    logic                             valid;
    logic                             ready;
    logic [dq_pkg::MODE_W-1:0]        mode;
    logic signed [dq_pkg::WORD_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [dq_pkg::WORD_W-1:0] popped_value;
    logic [dq_pkg::STAT_W-1:0]        status;
    logic [dq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output popped_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input popped_value, input status, input occupancy,
                    output ready);
endinterface

`default_nettype wire

>>> design/dq_ram.sv
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/dq_ctrl.sv
`default_nettype none

module dq_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [dq_pkg::MODE_W-1:0] in_mode,
    input  wire dq_pkg::word_t             in_value,
    input  wire logic                      out_ready,
    output dq_pkg::mem_cmd_t               mem_cmd,
    output dq_pkg::rsp_meta_t              meta,
    output dq_pkg::dq_stat_t               stat
);

    import dq_pkg::*;

    idx_t      head_reg, head_next;
    idx_t      tail_reg, tail_next;
    cnt_t      count_reg, count_next;
    rsp_meta_t meta_reg, meta_next;
    mem_cmd_t  cmd;
    status_t   status;
    logic      pop_ok;
    logic      accept;
    logic      empty;
    logic      full;
    mode_t     op;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == cnt_t'(DEPTH));
    assign in_ready = !meta_reg.valid || out_ready;
    assign accept   = in_valid && in_ready;
    assign op       = mode_t'(in_mode);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        cmd        = '0;
        cmd.wdata  = in_value;
        status     = ST_OK;
        pop_ok     = 1'b0;
        if (accept)
        begin
            case (op)
                MODE_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        head_next  = ring_prev(head_reg);
                        cmd.we     = 1'b1;
                        cmd.addr   = head_next;
                        count_next = count_reg + cnt_t'(1);
                    end
                end
                MODE_PUSH_REAR:
                begin
                    if (full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        cmd.we     = 1'b1;
                        cmd.addr   = tail_reg;
                        tail_next  = ring_next(tail_reg);
                        count_next = count_reg + cnt_t'(1);
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.re     = 1'b1;
                        cmd.addr   = head_reg;
                        head_next  = ring_next(head_reg);
                        count_next = count_reg - cnt_t'(1);
                        pop_ok     = 1'b1;
                    end
                end
                MODE_POP_REAR:
                begin
                    if (empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        tail_next  = ring_prev(tail_reg);
                        cmd.re     = 1'b1;
                        cmd.addr   = tail_next;
                        count_next = count_reg - cnt_t'(1);
                        pop_ok     = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result slot: RAM read data lands in the same cycle this becomes valid
    always_comb
    begin
        meta_next = meta_reg;
        if (accept)
        begin
            meta_next.valid  = 1'b1;
            meta_next.pop_ok = pop_ok;
            meta_next.status = status;
            meta_next.count  = count_next;
        end
        else if (out_ready)
        begin
            meta_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            meta_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            meta_reg  <= meta_next;
        end
    end

    assign mem_cmd = cmd;
    assign meta    = meta_reg;
    assign stat    = '{count: count_reg, head: head_reg, tail: tail_reg,
                       empty: empty, full: full};

endmodule

`default_nettype wire

>>> design/double_ended_queue_core.sv
// Double-ended queue of signed 32-bit words, DEPTH entries (package constant).
// req channel: mode (push front, push rear, pop front, pop rear) and value.
// rsp channel: one transfer per request with popped_value, status and
// occupancy after the operation.
// The response is valid in the cycle after the request transfer.
// Throughput: one request per clock unless rsp stalls; the entry RAM takes at
// most one access per operation (a write for a push, a read for a pop) on its
// single port pair, and the head/tail/count registers update in that cycle.
// A pop on an empty queue returns status empty and zero; a push on a full
// queue returns status full and drops the word. Neither changes state.
// Reset clears head, tail and count, so the queue starts empty; RAM contents
// are not cleared and need no clearing pass, since only written entries are
// ever read.
// When rsp stalls, the pending response holds and req.ready stays low until
// it is taken; a request is still taken in the cycle the response leaves.
`default_nettype none

module double_ended_queue_core (
    input  wire logic clk,
    input  wire logic rst_n,
    dq_req_if.sink    req,
    dq_rsp_if.source  rsp
);

    import dq_pkg::*;

    mem_cmd_t          mem_cmd;
    rsp_meta_t         meta;
    dq_stat_t          stat;
    logic [WORD_W-1:0] ram_rdata;
    logic              req_xfer;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_mode   (req.mode),
        .in_value  (req.value),
        .out_ready (rsp.ready),
        .mem_cmd   (mem_cmd),
        .meta      (meta),
        .stat      (stat)
    );

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.addr),
        .wdata (mem_cmd.wdata),
        .re    (mem_cmd.re),
        .raddr (mem_cmd.addr),
        .rdata (ram_rdata)
    );

    assign rsp.valid        = meta.valid;
    assign rsp.popped_value = meta.pop_ok ? word_t'(ram_rdata) : '0;
    assign rsp.status       = meta.status;
    assign rsp.occupancy    = OCC_W'(meta.count);

    assign req_xfer = req.valid && req.ready;

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req.mode == MODE_PUSH_FRONT || req.mode == MODE_PUSH_REAR)
            && !stat.full
        |=> stat.count == cnt_t'($past(stat.count) + cnt_t'(1)))
        else $error("count did not grow after a push");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req.mode == MODE_POP_FRONT || req.mode == MODE_POP_REAR)
            && stat.empty
        |=> rsp.valid && rsp.status == ST_EMPTY && rsp.popped_value == '0)
        else $error("pop on empty not reported");

    a_ring_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.empty |-> stat.head == stat.tail)
        else $error("empty queue with head and tail apart");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= cnt_t'(DEPTH))
        else $error("count above depth");

endmodule

`default_nettype wire
